// ===== rtl/core/clt_pkg.sv =====
package clt_pkg;

   // Byte codes the tokenizer looks at
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_N      = 8'h6E;
   localparam logic [7:0] CHR_R      = 8'h72;
   localparam logic [7:0] CHR_T      = 8'h74;

   // Register reset values
   localparam logic [7:0] WORD_BUFFER_LEN_RESET = 8'd25;
   localparam logic [7:0] MAX_ARGS_RESET        = 8'd16;

   // Depth of the queue between classifier and sequencer
   localparam int QUEUE_DEPTH = 4;

   // Register indexes on the csr port
   localparam logic [7:0] CSR_WORD_BUFFER_LEN = 8'd0;
   localparam logic [7:0] CSR_MAX_ARGS        = 8'd1;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_ESCAPE     = 3'd1,
      ERR_WORD_LONG  = 3'd2,
      ERR_OPEN_QUOTE = 3'd3,
      ERR_TOO_MANY   = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      CLS_OTHER  = 2'd0,
      CLS_QUOTE  = 2'd1,
      CLS_BSLASH = 2'd2,
      CLS_BLANK  = 2'd3
   } class_type;

   // One classified byte as it waits in the queue
   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
      class_type  cls;
      logic [7:0] esc_char;
      logic       esc_ok;
   } tok_type;

endpackage

// ===== rtl/core/clt_front.sv =====
module clt_front (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   output logic             push_valid,
   input  logic             push_ready,
   output clt_pkg::tok_type push_tok
);
   import clt_pkg::*;

   logic [7:0] ch;

   assign ch = req_tdata;

   // Classify the byte and decode it as if it followed a backslash
   always_comb begin
      push_tok.ch  = ch;
      push_tok.eol = req_tlast;

      if (ch == CHR_QUOTE) begin
         push_tok.cls = CLS_QUOTE;
      end else if (ch == CHR_BSLASH) begin
         push_tok.cls = CLS_BSLASH;
      end else if (ch == CHR_SPACE || (ch >= CHR_TAB && ch <= CHR_CR)) begin
         push_tok.cls = CLS_BLANK;
      end else begin
         push_tok.cls = CLS_OTHER;
      end

      push_tok.esc_ok = 1'b1;
      unique case (ch) inside
         CHR_N:   push_tok.esc_char = CHR_LF;
         CHR_R:   push_tok.esc_char = CHR_CR;
         CHR_T:   push_tok.esc_char = CHR_TAB;
         CHR_QUOTE, CHR_BSLASH, CHR_SPACE, CHR_DOLLAR: push_tok.esc_char = ch;
         default: begin
            push_tok.esc_char = ch;
            push_tok.esc_ok   = 1'b0;
         end
      endcase
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// ===== rtl/core/clt_queue.sv =====
module clt_queue #(
   parameter int DEPTH = clt_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  clt_pkg::tok_type push_tok,
   output logic             pop_valid,
   input  logic             pop_ready,
   output clt_pkg::tok_type pop_tok
);
   import clt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tok_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_tok    = mem[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

// ===== rtl/core/clt_back.sv =====
module clt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [7:0]       csr_data,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  clt_pkg::tok_type pop_tok,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import clt_pkg::*;

   // Configuration registers
   logic [7:0] word_buffer_len_ff;
   logic [7:0] max_args_ff;

   // Line state
   logic       quoting_ff, quoting_in;
   logic       escape_pending_ff, escape_pending_in;
   logic       inside_word_ff, inside_word_in;
   logic [7:0] word_length_ff, word_length_in;
   logic [7:0] words_done_ff, words_done_in;
   logic       discarding_ff, discarding_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       char_valid_ff, char_valid_in;
   logic       word_done_ff, word_done_in;
   logic       line_done_ff, line_done_in;
   logic [7:0] word_index_ff, word_index_in;
   logic [7:0] arg_count_ff, arg_count_in;
   err_type    error_code_ff, error_code_in;
   logic [7:0] bad_escape_ff, bad_escape_in;

   logic       pop;

   assign csr_ready = 1'b1;
   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         word_buffer_len_ff <= WORD_BUFFER_LEN_RESET;
         max_args_ff        <= MAX_ARGS_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_WORD_BUFFER_LEN) begin
            word_buffer_len_ff <= csr_data;
         end else if (csr_index == CSR_MAX_ARGS) begin
            max_args_ff <= csr_data;
         end
      end
   end

   // Apply one classified byte to the line state
   always_comb begin
      logic       failed;
      err_type    err;
      logic [7:0] bad;
      logic       have_char;
      logic [7:0] dc;
      logic       word_end;
      logic       esc_n;
      logic       quote_n;
      logic       inside_n;
      logic [8:0] wd_plus;

      quoting_in        = quoting_ff;
      escape_pending_in = escape_pending_ff;
      inside_word_in    = inside_word_ff;
      word_length_in    = word_length_ff;
      words_done_in     = words_done_ff;
      discarding_in     = discarding_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_char_in   = out_char_ff;
      char_valid_in = char_valid_ff;
      word_done_in  = word_done_ff;
      line_done_in  = line_done_ff;
      word_index_in = word_index_ff;
      arg_count_in  = arg_count_ff;
      error_code_in = error_code_ff;
      bad_escape_in = bad_escape_ff;

      failed    = 1'b0;
      err       = ERR_NONE;
      bad       = '0;
      have_char = 1'b0;
      dc        = pop_tok.ch;
      word_end  = 1'b0;
      esc_n     = escape_pending_ff;
      quote_n   = quoting_ff;
      inside_n  = inside_word_ff;
      wd_plus   = {1'b0, words_done_ff} + 9'd1;

      if (pop && discarding_ff) begin
         // Drop bytes up to and including the end of the failed line
         if (pop_tok.eol) begin
            discarding_in     = 1'b0;
            quoting_in        = 1'b0;
            escape_pending_in = 1'b0;
            inside_word_in    = 1'b0;
            word_length_in    = '0;
            words_done_in     = '0;
         end
      end else if (pop) begin
         if (escape_pending_ff) begin
            esc_n = 1'b0;
            if (!pop_tok.esc_ok) begin
               failed = 1'b1;
               err    = ERR_ESCAPE;
               bad    = pop_tok.ch;
            end else begin
               have_char = 1'b1;
               dc        = pop_tok.esc_char;
            end
         end else begin
            unique case (pop_tok.cls)
               CLS_QUOTE: begin
                  quote_n  = !quoting_ff;
                  inside_n = 1'b1;
               end
               CLS_BSLASH: begin
                  esc_n    = 1'b1;
                  inside_n = 1'b1;
               end
               CLS_BLANK: begin
                  if (quoting_ff) begin
                     have_char = 1'b1;
                  end else begin
                     word_end = inside_word_ff;
                  end
               end
               CLS_OTHER: have_char = 1'b1;
            endcase
         end

         // Length check on a word byte
         if (!failed && have_char) begin
            inside_n = 1'b1;
            if ({1'b0, word_length_ff} + 9'd1 >= {1'b0, word_buffer_len_ff}) begin
               failed = 1'b1;
               err    = ERR_WORD_LONG;
            end
         end

         // Line end checks in priority order
         if (!failed && pop_tok.eol) begin
            if (esc_n) begin
               failed = 1'b1;
               err    = ERR_ESCAPE;
            end else if (quote_n) begin
               failed = 1'b1;
               err    = ERR_OPEN_QUOTE;
            end else if (inside_n) begin
               word_end = 1'b1;
            end
         end

         if (!failed && word_end && wd_plus >= {1'b0, max_args_ff}) begin
            failed = 1'b1;
            err    = ERR_TOO_MANY;
         end

         // Build the result and the next state
         if (failed) begin
            rsp_valid_in      = 1'b1;
            out_char_in       = '0;
            char_valid_in     = 1'b0;
            word_done_in      = 1'b0;
            line_done_in      = 1'b1;
            word_index_in     = words_done_ff;
            arg_count_in      = words_done_ff;
            error_code_in     = err;
            bad_escape_in     = bad;
            quoting_in        = 1'b0;
            escape_pending_in = 1'b0;
            inside_word_in    = 1'b0;
            word_length_in    = '0;
            words_done_in     = '0;
            discarding_in     = !pop_tok.eol;
         end else begin
            quoting_in        = quote_n;
            escape_pending_in = esc_n;
            inside_word_in    = inside_n;
            word_length_in    = have_char ? word_length_ff + 8'd1 : word_length_ff;
            error_code_in     = ERR_NONE;
            bad_escape_in     = '0;
            word_index_in     = words_done_ff;
            out_char_in       = have_char ? dc : 8'd0;
            char_valid_in     = have_char;
            line_done_in      = pop_tok.eol;
            if (word_end) begin
               rsp_valid_in   = 1'b1;
               word_done_in   = 1'b1;
               arg_count_in   = wd_plus[7:0];
               words_done_in  = wd_plus[7:0];
               inside_word_in = 1'b0;
               word_length_in = '0;
            end else begin
               rsp_valid_in = have_char || pop_tok.eol;
               word_done_in = 1'b0;
               arg_count_in = words_done_ff;
            end
            if (pop_tok.eol) begin
               quoting_in        = 1'b0;
               escape_pending_in = 1'b0;
               inside_word_in    = 1'b0;
               word_length_in    = '0;
               words_done_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quoting_ff        <= 1'b0;
         escape_pending_ff <= 1'b0;
         inside_word_ff    <= 1'b0;
         word_length_ff    <= '0;
         words_done_ff     <= '0;
         discarding_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         quoting_ff        <= quoting_in;
         escape_pending_ff <= escape_pending_in;
         inside_word_ff    <= inside_word_in;
         word_length_ff    <= word_length_in;
         words_done_ff     <= words_done_in;
         discarding_ff     <= discarding_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      out_char_ff   <= out_char_in;
      char_valid_ff <= char_valid_in;
      word_done_ff  <= word_done_in;
      line_done_ff  <= line_done_in;
      word_index_ff <= word_index_in;
      arg_count_ff  <= arg_count_in;
      error_code_ff <= error_code_in;
      bad_escape_ff <= bad_escape_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = line_done_ff;
   assign rsp_tuser  = {word_done_ff, char_valid_ff};
   assign rsp_tdata  = {5'd0, bad_escape_ff, error_code_ff, arg_count_ff,
                        word_index_ff, out_char_ff};

endmodule

// ===== rtl/core/command_line_tokenizer.sv =====
// Command line tokenizer: splits a byte stream into shell-style words.
// req channel: one command line byte per word in tdata, tlast on the last
// byte of the line. rsp channel: at most one result per byte, carrying the
// decoded character, word and line end marks, counts and an error code.
// csr channel: register 0 is the word buffer length, register 1 the argument
// limit; write only while the block is idle. csr_ready is always high.
// A byte is classified on entry and waits in a small queue (QUEUE_DEPTH
// entries); the line sequencer takes one byte per cycle from the queue
// into a single result register. Throughput is one byte per cycle, also
// while a result waits, as long as rsp_tready stays high.
// A byte accepted on req is written into the queue, and its result is
// registered in the result register once the sequencer pops it.
// When the receiver stalls, the result register holds, the queue fills and
// req_tready drops once QUEUE_DEPTH bytes are waiting.
// Reset (synchronous) empties the queue, clears the line state and loads
// the register reset values 25 and 16. After an error, bytes are dropped
// without result up to and including the end of that line.
module command_line_tokenizer #(
   parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_char, [15:8] word_index, [23:16] arg_count,
   // [26:24] error_code, [34:27] bad_escape, [39:35] zero
   output logic [39:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [0] char_valid, [1] word_done
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import clt_pkg::*;

   logic    push_valid;
   logic    push_ready;
   tok_type push_tok;
   logic    pop_valid;
   logic    pop_ready;
   tok_type pop_tok;

   clt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_tok   (push_tok)
   );

   clt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_tok   (push_tok),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tok    (pop_tok)
   );

   clt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tok    (pop_tok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Every error result closes the line
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[26:24] != ERR_NONE) |-> rsp_tlast)
      else $error("error result without line end");

   // A decoded character never comes with an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[26:24] == ERR_NONE))
      else $error("character result carries an error");

   // A finished word raises the count to one past its index
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata[23:16] == rsp_tdata[15:8] + 8'd1))
      else $error("word end with inconsistent argument count");

endmodule
